FILE: sv/ftav_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the full-turn angle block.
// No dependencies; every other file imports this package.
package ftav_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int COORD_BITS_DEF = 16;
	localparam int CORDIC_STEPS   = 31;
	// Normalized vectors carry their larger component's top bit here.
	localparam int NORM_MSB       = 59;
	localparam int SHIFT_W        = 6;
	localparam int TURN_BITS      = 32;
	localparam int DATA_W         = 64;

	// Quarter-turn codes after the 90-degree reduction.
	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

	typedef struct packed {
		logic [DATA_W-1:0]    x;
		logic [DATA_W-1:0]    y;
		logic [TURN_BITS-1:0] z;
	} cordic_t;

	// atan(2^-i) in units of 2^-32 turn, rounded to nearest
	function automatic logic [TURN_BITS-1:0] atan_turn(input logic [4:0] idx);
		logic [TURN_BITS-1:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/ftav_vec.sv
`timescale 1ns / 1ps
// Vector front end: quarter-turn reduction, leading-one search and normalizing shift.
// Three pipeline stages (s2..s4); uses ftav_pkg.
module ftav_vec import ftav_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [COORD_BITS:0] vx,
	input  logic signed [COORD_BITS:0] vy,
	output cordic_t               vec
);

	localparam int MSB_W = $clog2(COORD_BITS);

	logic [COORD_BITS-1:0] rx, ry;
	quad_t                 quad;
	logic [COORD_BITS:0]   nx, ny;
	logic                  x_pos, x_neg, y_pos, y_neg;

	logic [COORD_BITS-1:0] rx_s2, ry_s2;
	quad_t                 quad_s2;

	logic [COORD_BITS-1:0] mx;
	logic [MSB_W-1:0]      msb;

	logic [COORD_BITS-1:0] rx_s3, ry_s3;
	quad_t                 quad_s3;
	logic [SHIFT_W-1:0]    shamt_s3;

	cordic_t               vec_s4;

	assign nx    = -vx;
	assign ny    = -vy;
	assign x_neg = vx[COORD_BITS];
	assign y_neg = vy[COORD_BITS];
	assign x_pos = !x_neg && (vx != '0);
	assign y_pos = !y_neg && (vy != '0);

	// turn into the sector x > 0, y >= 0
	always_comb begin
		priority if (x_pos && !y_neg) begin
			rx   = vx[COORD_BITS-1:0];
			ry   = vy[COORD_BITS-1:0];
			quad = QUAD_0;
		end else if (!x_pos && y_pos) begin
			rx   = vy[COORD_BITS-1:0];
			ry   = nx[COORD_BITS-1:0];
			quad = QUAD_90;
		end else if (x_neg && !y_pos) begin
			rx   = nx[COORD_BITS-1:0];
			ry   = ny[COORD_BITS-1:0];
			quad = QUAD_180;
		end else begin
			rx   = ny[COORD_BITS-1:0];
			ry   = vx[COORD_BITS-1:0];
			quad = QUAD_270;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s2   <= rx;
			ry_s2   <= ry;
			quad_s2 <= quad;
		end
	end

	assign mx = (rx_s2 > ry_s2) ? rx_s2 : ry_s2;

	// highest set bit of the larger component
	always_comb begin
		msb = '0;
		for (int i = 0; i < COORD_BITS; i++) begin
			if (mx[i]) begin
				msb = MSB_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s3    <= rx_s2;
			ry_s3    <= ry_s2;
			quad_s3  <= quad_s2;
			shamt_s3 <= SHIFT_W'(NORM_MSB) - SHIFT_W'(msb);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s4.x <= DATA_W'(rx_s3) << shamt_s3;
			vec_s4.y <= DATA_W'(ry_s3) << shamt_s3;
			vec_s4.z <= {quad_s3, {(TURN_BITS-2){1'b0}}};
		end
	end

	assign vec = vec_s4;

endmodule

FILE: sv/ftav_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC, one register stage per micro-rotation.
// Uses the arctangent table and cordic_t from ftav_pkg.
module ftav_cordic import ftav_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  cordic_t vec_in,
	output cordic_t vec_out
);

	cordic_t cord_s [0:CORDIC_STEPS];

	assign cord_s[0] = vec_in;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic [DATA_W-1:0]    xs, ys;
		logic [TURN_BITS-1:0] t;
		cordic_t              nxt;

		assign xs = cord_s[i].x >> i;
		assign ys = DATA_W'($signed(cord_s[i].y) >>> i);
		assign t  = atan_turn(5'(i));

		// rotate toward the x axis by the sign of y
		always_comb begin
			if (!cord_s[i].y[DATA_W-1]) begin
				nxt.x = cord_s[i].x + ys;
				nxt.y = cord_s[i].y - xs;
				nxt.z = cord_s[i].z + t;
			end else begin
				nxt.x = cord_s[i].x - ys;
				nxt.y = cord_s[i].y + xs;
				nxt.z = cord_s[i].z - t;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cord_s[i+1] <= nxt;
			end
		end
	end

	assign vec_out = cord_s[CORDIC_STEPS];

endmodule

FILE: sv/full_turn_angle_between_vectors.sv
`timescale 1ns / 1ps
// Full-turn angle between two vectors: top level, operand stage, angle difference and rounding.
// Depends on ftav_pkg, ftav_vec and ftav_cordic.

// Takes one beat per clock while not stalled and returns one result beat per input
// beat, in order: one stage forms the vectors, three reduce and normalize them,
// 31 CORDIC stages (one per micro-rotation, one lane per vector) find the
// directions, one subtracts them and one rounds to ANGLE_BITS. The whole
// pipeline holds while a finished result is not taken; a zero-length vector yields
// angle_code 0 with degenerate set.
module full_turn_angle_between_vectors import ftav_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ANGLE_BITS-1:0]        angle_code,
	output logic                         degenerate
);

	localparam int LAT  = CORDIC_STEPS + 6;
	localparam int SH   = TURN_BITS - ANGLE_BITS;
	localparam logic [TURN_BITS:0] HALF = ((TURN_BITS+1)'(1) << SH) >> 1;

	logic                  en;
	logic [LAT:1]          vld_q;
	logic [LAT:1]          deg_q;
	logic                  deg_in;

	logic signed [COORD_BITS:0] ax_s1, ay_s1, bx_s1, by_s1;

	cordic_t               va_norm, vb_norm, va_dir, vb_dir;
	logic [TURN_BITS-1:0]  diff_s36;
	logic [TURN_BITS:0]    rnd;
	logic [ANGLE_BITS-1:0] angle_s37;

	// advance everything unless the output beat is stuck
	assign en       = !vld_q[LAT] || out_ready;
	assign in_ready = en;

	assign deg_in = ((first_x == center_x) && (first_y == center_y)) ||
			((second_x == center_x) && (second_y == center_y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			deg_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], in_valid};
			deg_q <= {deg_q[LAT-1:1], deg_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= {first_x[COORD_BITS-1], first_x} - {center_x[COORD_BITS-1], center_x};
			ay_s1 <= {first_y[COORD_BITS-1], first_y} - {center_y[COORD_BITS-1], center_y};
			bx_s1 <= {second_x[COORD_BITS-1], second_x} - {center_x[COORD_BITS-1], center_x};
			by_s1 <= {second_y[COORD_BITS-1], second_y} - {center_y[COORD_BITS-1], center_y};
		end
	end

	ftav_vec #(.COORD_BITS(COORD_BITS)) u_vec_a (
		.clk (clk),
		.en  (en),
		.vx  (ax_s1),
		.vy  (ay_s1),
		.vec (va_norm)
	);

	ftav_vec #(.COORD_BITS(COORD_BITS)) u_vec_b (
		.clk (clk),
		.en  (en),
		.vx  (bx_s1),
		.vy  (by_s1),
		.vec (vb_norm)
	);

	ftav_cordic u_cordic_a (
		.clk     (clk),
		.en      (en),
		.vec_in  (va_norm),
		.vec_out (va_dir)
	);

	ftav_cordic u_cordic_b (
		.clk     (clk),
		.en      (en),
		.vec_in  (vb_norm),
		.vec_out (vb_dir)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s36 <= vb_dir.z - va_dir.z;
		end
	end

	// round to nearest; the carry out wraps a near-full turn to zero
	assign rnd = {1'b0, diff_s36} + HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s37 <= deg_q[LAT-1] ? '0 : rnd[TURN_BITS-1:SH];
		end
	end

	assign out_valid  = vld_q[LAT];
	assign angle_code = angle_s37;
	assign degenerate = deg_q[LAT];

`ifndef SYNTHESIS
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> angle_code == '0)
		else $error("degenerate beat with nonzero angle");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_q) && $stable(deg_q))
		else $error("pipeline moved while stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[1] && (deg_q[1] == $past(deg_in)))
		else $error("accepted beat not captured in first stage");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");
`endif

endmodule
